// ----- rtl/cctc_pkg.sv -----
// ----------------------------------------------------------------------------
// cctc_pkg
// Shared types and constants for the cycle count to timespec converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cctc_pkg;

  localparam int unsigned SEC_CELLS  = 64;
  localparam int unsigned NS_CELLS   = 30;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [29:0] NS_PER_S    = 30'd1000000000;
  localparam logic [9:0]  NS_PER_US   = 10'd1000;
  // floor(x / 1000) == (x * MICRO_RECIP) >> MICRO_SHIFT for x < 2^30
  localparam logic [30:0] MICRO_RECIP = 31'd1099511628;
  localparam int unsigned MICRO_SHIFT = 40;

  localparam logic signed [31:0] NS_ONE = 32'sd1000000000;
  localparam logic signed [31:0] NS_TWO = 32'sd2000000000;

  localparam logic [CFG_IDX_W-1:0] REG_TB_EN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HZ        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_S    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_NS   = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOTSUP  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_MONO = 2'd0,
    KIND_REAL = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic        zero;
    logic [31:0] rem;
    logic [63:0] word;
    logic [63:0] sec;
  } stage_t;

endpackage

`default_nettype wire

// ----- rtl/cctc_div_cell.sv -----
// ----------------------------------------------------------------------------
// cctc_div_cell
// One restoring-division step: shifts one dividend bit into the partial
// remainder and one quotient bit into the word, then registers the stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cctc_div_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [31:0]     hz_i,
  input  wire logic            valid_i,
  input  wire cctc_pkg::stage_t stage_i,
  output logic                 valid_o,
  output cctc_pkg::stage_t     stage_o
);

  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             ge;
  cctc_pkg::stage_t stage_d;
  cctc_pkg::stage_t stage_q;
  logic             valid_q;

  always_comb begin
    trial = {stage_i.rem, stage_i.word[63]};
    diff  = trial - {1'b0, hz_i};
    ge    = (trial >= {1'b0, hz_i});
    stage_d      = stage_i;
    stage_d.rem  = ge ? diff[31:0] : trial[31:0];
    stage_d.word = {stage_i.word[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- rtl/cctc_finish.sv -----
// ----------------------------------------------------------------------------
// cctc_finish
// Adds the wall epoch, normalizes nanoseconds, derives microseconds and
// holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cctc_finish (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                wall_en_i,
  input  wire logic [63:0]         wall_s_i,
  input  wire logic signed [30:0]  wall_ns_i,
  input  wire logic                valid_i,
  input  wire cctc_pkg::stage_t    stage_i,
  output logic                     valid_o,
  output logic [63:0]              sec_o,
  output logic [29:0]              ns_o,
  output logic [19:0]              us_o,
  output cctc_pkg::status_e        status_o
);

  // stage A: epoch add
  logic                 a_valid_q;
  cctc_pkg::status_e    a_status_q;
  logic [63:0]          a_sec_q;
  logic signed [31:0]   a_ns_q;
  logic [63:0]          a_sec_d;
  logic signed [31:0]   a_ns_d;
  logic [63:0]          sec_base;
  logic [29:0]          ns_base;
  logic                 use_wall;

  // stage B: normalize
  logic                 b_valid_q;
  cctc_pkg::status_e    b_status_q;
  logic [63:0]          b_sec_q;
  logic [29:0]          b_ns_q;
  logic signed [31:0]   b_ns_d;
  logic signed [2:0]    adj;

  // stage C: output
  logic                 c_valid_q;
  cctc_pkg::status_e    c_status_q;
  logic [63:0]          c_sec_q;
  logic [29:0]          c_ns_q;
  logic [19:0]          c_us_q;
  logic [60:0]          us_prod;

  always_comb begin
    sec_base = stage_i.zero ? 64'd0 : stage_i.sec;
    ns_base  = stage_i.zero ? 30'd0 : stage_i.word[29:0];
    use_wall = (stage_i.kind == cctc_pkg::KIND_REAL) && wall_en_i;
    if (stage_i.status != cctc_pkg::ST_OK) begin
      a_sec_d = 64'd0;
      a_ns_d  = 32'sd0;
    end else if (use_wall) begin
      a_sec_d = wall_s_i + sec_base;
      a_ns_d  = 32'(wall_ns_i) + $signed({2'b00, ns_base});
    end else begin
      a_sec_d = sec_base;
      a_ns_d  = $signed({2'b00, ns_base});
    end
  end

  always_comb begin
    priority if (a_ns_q >= cctc_pkg::NS_TWO) begin
      b_ns_d = a_ns_q - cctc_pkg::NS_TWO;
      adj    = 3'sd2;
    end else if (a_ns_q >= cctc_pkg::NS_ONE) begin
      b_ns_d = a_ns_q - cctc_pkg::NS_ONE;
      adj    = 3'sd1;
    end else if (a_ns_q < -cctc_pkg::NS_ONE) begin
      b_ns_d = a_ns_q + cctc_pkg::NS_TWO;
      adj    = -3'sd2;
    end else if (a_ns_q < 32'sd0) begin
      b_ns_d = a_ns_q + cctc_pkg::NS_ONE;
      adj    = -3'sd1;
    end else begin
      b_ns_d = a_ns_q;
      adj    = 3'sd0;
    end
  end

  assign us_prod = 61'(b_ns_q) * 61'(cctc_pkg::MICRO_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_status_q <= stage_i.status;
      a_sec_q    <= a_sec_d;
      a_ns_q     <= a_ns_d;
      b_status_q <= a_status_q;
      b_sec_q    <= a_sec_q + 64'($signed(adj));
      b_ns_q     <= b_ns_d[29:0];
      c_status_q <= b_status_q;
      c_sec_q    <= b_sec_q;
      c_ns_q     <= b_ns_q;
      c_us_q     <= us_prod[cctc_pkg::MICRO_SHIFT +: 20];
    end
  end

  assign valid_o  = c_valid_q;
  assign sec_o    = c_sec_q;
  assign ns_o     = c_ns_q;
  assign us_o     = c_us_q;
  assign status_o = c_status_q;

endmodule

`default_nettype wire

// ----- rtl/cycle_count_to_timespec_clock.sv -----
// ----------------------------------------------------------------------------
// cycle_count_to_timespec_clock
// Converts a free-running cycle count and a clock id into a timespec.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle and returns one result per transfer, in order,
// after a front stage for the start subtraction, a row of 64 division cells
// for whole seconds, one multiply stage, a row of 30 cells for nanoseconds,
// and three stages for the epoch add, normalization and microseconds. The
// whole pipeline stalls while a result waits on m_axis_tready. The user must
// write configuration only while no transfer is in flight; it is not checked.
`default_nettype none

module cycle_count_to_timespec_clock (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cctc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]                    cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [63:0]                    s_axis_tdata,  // now_cycles
  input  wire logic [3:0]                     s_axis_tuser,  // clock_id
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // time_seconds[63:0], time_nanos[93:64], time_micros[113:94], zero pad
  output logic [119:0]                        m_axis_tdata,
  output logic [1:0]                          m_axis_tuser   // status
);

  logic               tb_en_q;
  logic [63:0]        start_q;
  logic [31:0]        hz_q;
  logic               wall_en_q;
  logic [63:0]        wall_s_q;
  logic signed [30:0] wall_ns_q;

  logic adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_en_q   <= 1'b0;
      start_q   <= 64'd0;
      hz_q      <= 32'd0;
      wall_en_q <= 1'b0;
      wall_s_q  <= 64'd0;
      wall_ns_q <= 31'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cctc_pkg::REG_TB_EN:   tb_en_q   <= cfg_data_i[0];
        cctc_pkg::REG_START:   start_q   <= cfg_data_i;
        cctc_pkg::REG_HZ:      hz_q      <= cfg_data_i[31:0];
        cctc_pkg::REG_WALL_EN: wall_en_q <= cfg_data_i[0];
        cctc_pkg::REG_WALL_S:  wall_s_q  <= cfg_data_i;
        cctc_pkg::REG_WALL_NS: wall_ns_q <= $signed(cfg_data_i[30:0]);
        default: ;
      endcase
    end
  end

  // front stage
  cctc_pkg::stage_t front_d;
  cctc_pkg::stage_t front_q;
  logic             front_valid_q;

  always_comb begin
    front_d       = '0;
    front_d.zero  = !tb_en_q;
    front_d.word  = (s_axis_tdata > start_q) ? (s_axis_tdata - start_q) : 64'd0;
    unique case (s_axis_tuser)
      4'd1, 4'd4, 4'd6, 4'd7: front_d.kind = cctc_pkg::KIND_MONO;
      4'd0, 4'd5:             front_d.kind = cctc_pkg::KIND_REAL;
      default:                front_d.kind = cctc_pkg::KIND_ERR;
    endcase
    if (s_axis_tuser == 4'd2 || s_axis_tuser == 4'd3) begin
      front_d.status = cctc_pkg::ST_NOTSUP;
    end else if (front_d.kind == cctc_pkg::KIND_ERR) begin
      front_d.status = cctc_pkg::ST_INVALID;
    end else if (tb_en_q && hz_q == 32'd0) begin
      front_d.status = cctc_pkg::ST_INVALID;
    end else begin
      front_d.status = cctc_pkg::ST_OK;
    end
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (adv) begin
      front_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      front_q <= front_d;
    end
  end

  // seconds row
  cctc_pkg::stage_t sec_stage [cctc_pkg::SEC_CELLS+1];
  logic             sec_valid [cctc_pkg::SEC_CELLS+1];

  assign sec_stage[0] = front_q;
  assign sec_valid[0] = front_valid_q;

  for (genvar g = 0; g < cctc_pkg::SEC_CELLS; g++) begin : g_sec
    cctc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .hz_i    (hz_q),
      .valid_i (sec_valid[g]),
      .stage_i (sec_stage[g]),
      .valid_o (sec_valid[g+1]),
      .stage_o (sec_stage[g+1])
    );
  end

  // remainder scaled to nanoseconds, then divided again
  cctc_pkg::stage_t mul_d;
  cctc_pkg::stage_t mul_q;
  logic             mul_valid_q;
  logic [61:0]      rem_prod;

  assign rem_prod = 62'(sec_stage[cctc_pkg::SEC_CELLS].rem) * 62'(cctc_pkg::NS_PER_S);

  always_comb begin
    mul_d      = sec_stage[cctc_pkg::SEC_CELLS];
    mul_d.sec  = sec_stage[cctc_pkg::SEC_CELLS].word;
    mul_d.rem  = rem_prod[61:30];
    mul_d.word = {rem_prod[29:0], 34'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (adv) begin
      mul_valid_q <= sec_valid[cctc_pkg::SEC_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q <= mul_d;
    end
  end

  cctc_pkg::stage_t ns_stage [cctc_pkg::NS_CELLS+1];
  logic             ns_valid [cctc_pkg::NS_CELLS+1];

  assign ns_stage[0] = mul_q;
  assign ns_valid[0] = mul_valid_q;

  for (genvar g = 0; g < cctc_pkg::NS_CELLS; g++) begin : g_ns
    cctc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .hz_i    (hz_q),
      .valid_i (ns_valid[g]),
      .stage_i (ns_stage[g]),
      .valid_o (ns_valid[g+1]),
      .stage_o (ns_stage[g+1])
    );
  end

  logic [63:0]       out_sec;
  logic [29:0]       out_ns;
  logic [19:0]       out_us;
  cctc_pkg::status_e out_status;

  cctc_finish u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .wall_en_i (wall_en_q),
    .wall_s_i  (wall_s_q),
    .wall_ns_i (wall_ns_q),
    .valid_i   (ns_valid[cctc_pkg::NS_CELLS]),
    .stage_i   (ns_stage[cctc_pkg::NS_CELLS]),
    .valid_o   (m_axis_tvalid),
    .sec_o     (out_sec),
    .ns_o      (out_ns),
    .us_o      (out_us),
    .status_o  (out_status)
  );

  assign m_axis_tdata = {6'd0, out_us, out_ns, out_sec};
  assign m_axis_tuser = out_status;

  // error results carry zero time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_status != cctc_pkg::ST_OK
      |-> out_sec == 64'd0 && out_ns == 30'd0 && out_us == 20'd0)
    else $error("error result with nonzero time");

  // microseconds track nanoseconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (40'(out_us) * 40'(cctc_pkg::NS_PER_US) <= 40'(out_ns)) &&
      (40'(out_ns) - 40'(out_us) * 40'(cctc_pkg::NS_PER_US) < 40'(cctc_pkg::NS_PER_US)))
    else $error("micros do not match nanos");

  // a stalled result stays put and blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready ##1 m_axis_tvalid)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

// ----- sim/tb_cycle_count_to_timespec_clock.sv -----
// ----------------------------------------------------------------------------
// tb_cycle_count_to_timespec_clock
// Checks cycle count to timespec conversion against a behavioral predictor.
// ----------------------------------------------------------------------------
// A directed table covers clock kinds, error codes, clamping, wraps and epoch
// normalization; random phases then sweep register settings with random
// handshake gaps, including one long output stall that backs up the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cycle_count_to_timespec_clock;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 110;

  typedef struct packed {
    logic [63:0]       sec;
    logic [29:0]       ns;
    logic [19:0]       us;
    cctc_pkg::status_e st;
  } tspec_t;

  typedef struct {
    logic [63:0] now;
    logic [3:0]  id;
    logic        known;
    tspec_t      res;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [cctc_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [3:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  cycle_count_to_timespec_clock u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // register shadow
  logic        tb_en, wall_en;
  logic [63:0] start_cyc, wall_s;
  logic [31:0] hz;
  logic signed [30:0] wall_ns;

  tspec_t time_q[$];
  int n_err, n_res, n_sent;
  bit hold_rx;

  function automatic tspec_t convert_time(logic [63:0] now, logic [3:0] id);
    tspec_t r;
    logic [63:0] el, sec, rem, ns;
    logic signed [63:0] n, b;
    bit mono, real_k;
    r = '0;
    mono = (id == 1 || id == 4 || id == 6 || id == 7);
    real_k = (id == 0 || id == 5);
    sec = 0;
    ns = 0;
    if (id == 2 || id == 3) begin
      r.st = cctc_pkg::ST_NOTSUP;
      return r;
    end
    if (!mono && !real_k) begin
      r.st = cctc_pkg::ST_INVALID;
      return r;
    end
    if (tb_en) begin
      if (hz == 0) begin
        r.st = cctc_pkg::ST_INVALID;
        return r;
      end
      el = (now > start_cyc) ? now - start_cyc : 64'd0;
      sec = el / hz;
      rem = el % hz;
      ns = (rem * 64'd1000000000) / hz;
    end
    if (real_k && wall_en) begin
      n = 64'(wall_ns) + $signed(ns);
      sec = sec + wall_s;
      if (n >= 64'sd1000000000) begin
        sec = sec + 64'(n / 64'sd1000000000);
        n = n % 64'sd1000000000;
      end else if (n < 0) begin
        b = (-n + 64'sd999999999) / 64'sd1000000000;
        sec = sec - 64'(b);
        n = n + b * 64'sd1000000000;
      end
      ns = 64'(n);
    end
    r.sec = sec;
    r.ns = ns[29:0];
    r.us = 20'(ns / 1000);
    r.st = cctc_pkg::ST_OK;
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(logic [cctc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      cctc_pkg::REG_TB_EN:   tb_en = val[0];
      cctc_pkg::REG_START:   start_cyc = val;
      cctc_pkg::REG_HZ:      hz = val[31:0];
      cctc_pkg::REG_WALL_EN: wall_en = val[0];
      cctc_pkg::REG_WALL_S:  wall_s = val;
      cctc_pkg::REG_WALL_NS: wall_ns = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic te, logic [63:0] st, logic [31:0] f, logic we,
                         logic [63:0] ws, logic [30:0] wn);
    write_reg(cctc_pkg::REG_TB_EN, 64'(te));
    write_reg(cctc_pkg::REG_START, st);
    write_reg(cctc_pkg::REG_HZ, 64'(f));
    write_reg(cctc_pkg::REG_WALL_EN, 64'(we));
    write_reg(cctc_pkg::REG_WALL_S, ws);
    write_reg(cctc_pkg::REG_WALL_NS, 64'(wn));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (time_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  // one transfer on the input side, with its expectation queued at acceptance
  task automatic send_item(logic [63:0] now, logic [3:0] id, bit known, tspec_t res);
    tspec_t e;
    int gap;
    gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= now;
    s_axis_tuser <= id;
    do @(posedge clk_i); while (!s_axis_tready);
    e = convert_time(now, id);
    if (known && e != res) begin
      n_err++;
      if (n_err <= 10) $display("table row mismatch id=%0d exp %p pred %p", id, res, e);
    end
    time_q.push_back(e);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'($urandom_range(0, 100000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [30:0] rand_wns();
    case ($urandom_range(0, 4))
      0: return 31'd999999999;
      1: return -31'sd999999999;
      2: return 31'($urandom);
      default: return 31'($signed($urandom_range(0, 1999999998)) - 999999999);
    endcase
  endfunction

  // receiver
  initial begin
    tspec_t a, e;
    int wait_c;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk_i);
        hold_rx = 0;
      end
      wait_c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : 0;
      if (wait_c != 0) begin
        m_axis_tready <= 0;
        repeat (wait_c) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      a.sec = m_axis_tdata[63:0];
      a.ns = m_axis_tdata[93:64];
      a.us = m_axis_tdata[113:94];
      a.st = cctc_pkg::status_e'(m_axis_tuser);
      n_res++;
      if (time_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %p", a);
      end else begin
        e = time_q.pop_front();
        if (a != e) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch sec %h/%h ns %0d/%0d us %0d/%0d st %0d/%0d",
                     e.sec, a.sec, e.ns, a.ns, e.us, a.us, e.st, a.st);
        end
      end
    end
  end

  row_t tbl[$];

  task automatic add_row(logic [63:0] now, logic [3:0] id, bit known,
                         logic [63:0] s, logic [29:0] ns, cctc_pkg::status_e st);
    row_t r;
    r.now = now;
    r.id = id;
    r.known = known;
    r.res = '{sec: s, ns: ns, us: 20'(ns / 1000), st: st};
    tbl.push_back(r);
  endtask

  initial begin
    int ph;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    n_err = 0;
    n_res = 0;
    n_sent = 0;
    hold_rx = 0;
    tb_en = 0;
    wall_en = 0;
    start_cyc = 0;
    wall_s = 0;
    hz = 0;
    wall_ns = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // after reset: everything zero time
    add_row('1, 4'd0, 1, 0, 0, cctc_pkg::ST_OK);
    add_row(64'd5, 4'd1, 1, 0, 0, cctc_pkg::ST_OK);
    add_row(64'd5, 4'd2, 1, 0, 0, cctc_pkg::ST_NOTSUP);
    add_row(64'd5, 4'd3, 1, 0, 0, cctc_pkg::ST_NOTSUP);
    add_row(64'd5, 4'd8, 1, 0, 0, cctc_pkg::ST_INVALID);
    add_row(64'd5, 4'd15, 1, 0, 0, cctc_pkg::ST_INVALID);
    foreach (tbl[i]) send_item(tbl[i].now, tbl[i].id, tbl[i].known, tbl[i].res);
    drain();

    // zero frequency with timebase on
    set_all(1, 0, 0, 0, 0, 0);
    tbl.delete();
    add_row(64'd100, 4'd1, 1, 0, 0, cctc_pkg::ST_INVALID);
    add_row(64'd100, 4'd0, 1, 0, 0, cctc_pkg::ST_INVALID);
    add_row(64'd100, 4'd7, 1, 0, 0, cctc_pkg::ST_INVALID);
    foreach (tbl[i]) send_item(tbl[i].now, tbl[i].id, tbl[i].known, tbl[i].res);
    drain();

    // extremes: 1 Hz, 4 GHz, count below start, epoch normalization
    set_all(1, 64'd10, 32'd1, 1, '1, -31'sd999999999);
    tbl.delete();
    add_row(64'd3, 4'd1, 1, 0, 0, cctc_pkg::ST_OK);
    add_row(64'd10, 4'd6, 1, 0, 0, cctc_pkg::ST_OK);
    add_row('1, 4'd4, 1, 64'hFFFF_FFFF_FFFF_FFF5, 0, cctc_pkg::ST_OK);
    add_row(64'd3, 4'd0, 1, 64'hFFFF_FFFF_FFFF_FFFE, 30'd1, cctc_pkg::ST_OK);
    add_row(64'd13, 4'd5, 0, 0, 0, cctc_pkg::ST_OK);
    foreach (tbl[i]) send_item(tbl[i].now, tbl[i].id, tbl[i].known, tbl[i].res);
    drain();
    set_all(1, 0, 32'd4000000000, 1, 64'h7FFF_FFFF_FFFF_FFFF, 31'h3FFF_FFFF);
    tbl.delete();
    add_row('1, 4'd1, 0, 0, 0, cctc_pkg::ST_OK);
    add_row('1, 4'd0, 0, 0, 0, cctc_pkg::ST_OK);
    add_row(64'd3999999999, 4'd5, 0, 0, 0, cctc_pkg::ST_OK);
    add_row(64'd1, 4'd7, 0, 0, 0, cctc_pkg::ST_OK);
    foreach (tbl[i]) send_item(tbl[i].now, tbl[i].id, tbl[i].known, tbl[i].res);
    drain();
    set_all(0, 0, 32'd7, 1, 64'h8000_0000_0000_0000, 31'h4000_0000);
    tbl.delete();
    add_row(64'd50, 4'd0, 1, 64'h7FFF_FFFF_FFFF_FFFE, 30'd926258176, cctc_pkg::ST_OK);
    add_row(64'd50, 4'd1, 1, 0, 0, cctc_pkg::ST_OK);
    foreach (tbl[i]) send_item(tbl[i].now, tbl[i].id, tbl[i].known, tbl[i].res);
    drain();

    // random phases
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_all(1, 0, 32'd4000000000, 1, 0, 31'd999999999);
        1: set_all(1, '1, 32'd1, 1, '1, -31'sd999999999);
        default: set_all($urandom_range(0, 5) != 0, rand64(),
                         $urandom_range(0, 7) == 0 ? 32'd0 :
                         ($urandom_range(0, 1) ? $urandom_range(1, 4000000000)
                                               : $urandom_range(1, 1000)),
                         $urandom_range(0, 1), rand64(), rand_wns());
      endcase
      if (ph == 4) hold_rx = 1;
      repeat (100) begin
        logic [3:0] id;
        logic [63:0] now;
        id = $urandom_range(0, 9) < 8 ? 4'($urandom_range(0, 7)) : 4'($urandom);
        now = $urandom_range(0, 3) == 0 ? rand64() : start_cyc + {$urandom, $urandom} >> $urandom_range(0, 60);
        send_item(now, id, 0, '0);
      end
      drain();
    end

    $display("sent %0d transfers, received %0d results over 15 register settings",
             n_sent, n_res);
    if (n_err == 0 && time_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("errors %0d, left over %0d", n_err, time_q.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
